// ===== sv/dsot_pkg.sv =====
// Shared types, codes and sizing constants of the display seat owner table.
`timescale 1ns / 1ps

package dsot_pkg;

    localparam int NUM_SEATS_DEF = 8;
    localparam int NUM_SEATS_MAX = 64;
    localparam int IDX_MAX_W     = $clog2(NUM_SEATS_MAX);

    localparam int OWNER_W = 16;
    localparam int ADDR_W  = 48;
    localparam int SEAT_W  = 4;

    localparam logic [1:0] FN_REGISTER = 2'd0;
    localparam logic [1:0] FN_RELEASE  = 2'd1;
    localparam logic [1:0] FN_SWITCH   = 2'd2;
    localparam logic [1:0] FN_READ     = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_SEAT = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_UPDATE = 5'b00100,
        S_FETCH  = 5'b01000,
        S_RESULT = 5'b10000
    } seq_state_t;

    typedef struct packed {
        logic                 wr_en;
        logic [IDX_MAX_W-1:0] wr_idx;
        logic [OWNER_W-1:0]   wr_owner;
        logic [ADDR_W-1:0]    wr_addr;
        logic [IDX_MAX_W-1:0] own_idx;
        logic [IDX_MAX_W-1:0] adr_idx;
    } mem_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [SEAT_W-1:0]  seat_out;
        logic [ADDR_W-1:0]  address_out;
        logic [SEAT_W-1:0]  active_seat;
        logic               active_valid;
        logic [OWNER_W-1:0] active_owner;
        logic [SEAT_W-1:0]  used_count;
    } result_t;

endpackage

// ===== sv/dsot_cmd_if.sv =====
// Request channel of the seat table: operation code and operands.
`timescale 1ns / 1ps

interface dsot_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] owner_id;
    logic [47:0] frame_address;
    logic [3:0]  seat_number;

    modport source (output valid, func, owner_id, frame_address, seat_number, input ready);
    modport sink (input valid, func, owner_id, frame_address, seat_number, output ready);
endinterface

// ===== sv/dsot_res_if.sv =====
// Result channel of the seat table: status, seat, address and active seat report.
`timescale 1ns / 1ps

interface dsot_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  seat_out;
    logic [47:0] address_out;
    logic [3:0]  active_seat;
    logic        active_valid;
    logic [15:0] active_owner;
    logic [3:0]  used_count;

    modport source (output valid, status, seat_out, address_out, active_seat,
                    active_valid, active_owner, used_count, input ready);
    modport sink (input valid, status, seat_out, address_out, active_seat,
                  active_valid, active_owner, used_count, output ready);
endinterface

// ===== sv/dsot_mem.sv =====
// Owner id and frame address memories, one write and one registered read each.
`timescale 1ns / 1ps

module dsot_mem
    import dsot_pkg::*;
#(
    parameter int NUM_SEATS = NUM_SEATS_DEF
) (
    input  logic               clk,
    input  mem_req_t           req,
    output logic [OWNER_W-1:0] owner_rd,
    output logic [ADDR_W-1:0]  addr_rd
);

    localparam int IW = (NUM_SEATS > 1) ? $clog2(NUM_SEATS) : 1;

    logic [OWNER_W-1:0] owner_mem [NUM_SEATS];
    logic [ADDR_W-1:0]  address_mem [NUM_SEATS];
    logic [OWNER_W-1:0] owner_rd_reg;
    logic [ADDR_W-1:0]  addr_rd_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            owner_mem[req.wr_idx[IW-1:0]]   <= req.wr_owner;
            address_mem[req.wr_idx[IW-1:0]] <= req.wr_addr;
        end
        owner_rd_reg <= owner_mem[req.own_idx[IW-1:0]];
        addr_rd_reg  <= address_mem[req.adr_idx[IW-1:0]];
    end

    assign owner_rd = owner_rd_reg;
    assign addr_rd  = addr_rd_reg;

endmodule

// ===== sv/dsot_seq.sv =====
// Sequencer: register/release scan seats one per cycle via owner compare, then apply the op.
`timescale 1ns / 1ps

module dsot_seq
    import dsot_pkg::*;
#(
    parameter int NUM_SEATS = NUM_SEATS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    dsot_cmd_if.sink           cmd,
    output mem_req_t           mem_req,
    input  logic [OWNER_W-1:0] owner_rd,
    input  logic [ADDR_W-1:0]  addr_rd,
    output logic               res_vld,
    input  logic               res_ready,
    output result_t            res_data
);

    localparam int IW = (NUM_SEATS > 1) ? $clog2(NUM_SEATS) : 1;
    localparam int AW = $clog2(NUM_SEATS + 1);

    seq_state_t state_reg, state_next;

    logic [1:0]            func_reg, func_next;
    logic [OWNER_W-1:0]    id_reg, id_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [SEAT_W-1:0]     sn_reg, sn_next;
    logic [NUM_SEATS-1:0]  used_reg, used_next;
    logic [AW-1:0]         active_reg, active_next;
    logic [AW-1:0]         count_reg, count_next;
    logic [AW-1:0]         cnt_reg, cnt_next;
    logic [IW-1:0]         cmp_idx_reg, cmp_idx_next;
    logic                  found_reg, found_next;
    logic [IW-1:0]         found_idx_reg, found_idx_next;
    logic                  free_ok_reg, free_ok_next;
    logic [IW-1:0]         free_idx_reg, free_idx_next;
    logic                  l1_ok_reg, l1_ok_next;
    logic [IW-1:0]         l1_idx_reg, l1_idx_next;
    logic                  l2_ok_reg, l2_ok_next;
    logic [IW-1:0]         l2_idx_reg, l2_idx_next;
    logic [1:0]            status_reg, status_next;
    logic [AW-1:0]         seat_out_reg, seat_out_next;

    logic [IW-1:0] sn_idx;
    logic [IW-1:0] act_idx;
    logic          seat_ok;
    logic          act_ok;
    logic          cmp_used;
    logic          cmp_match;

    assign sn_idx    = IW'(sn_reg - 4'd1);
    assign act_idx   = IW'(active_reg - AW'(1));
    assign seat_ok   = (sn_reg != '0) && (32'(sn_reg) <= NUM_SEATS) && used_reg[sn_idx];
    assign act_ok    = (active_reg != '0) && used_reg[act_idx];
    assign cmp_used  = used_reg[cmp_idx_reg];
    assign cmp_match = cmp_used && (owner_rd == id_reg);

    assign cmd.ready = (state_reg == S_IDLE);
    assign res_vld   = (state_reg == S_RESULT);

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        id_next        = id_reg;
        addr_next      = addr_reg;
        sn_next        = sn_reg;
        used_next      = used_reg;
        active_next    = active_reg;
        count_next     = count_reg;
        cnt_next       = cnt_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        free_ok_next   = free_ok_reg;
        free_idx_next  = free_idx_reg;
        l1_ok_next     = l1_ok_reg;
        l1_idx_next    = l1_idx_reg;
        l2_ok_next     = l2_ok_reg;
        l2_idx_next    = l2_idx_reg;
        status_next    = status_reg;
        seat_out_next  = seat_out_reg;

        mem_req          = '0;
        mem_req.own_idx  = IDX_MAX_W'(cnt_reg[IW-1:0]);
        mem_req.adr_idx  = IDX_MAX_W'(sn_idx);
        mem_req.wr_idx   = IDX_MAX_W'(free_idx_reg);
        mem_req.wr_owner = id_reg;
        mem_req.wr_addr  = addr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    func_next     = cmd.func;
                    id_next       = cmd.owner_id;
                    addr_next     = cmd.frame_address;
                    sn_next       = cmd.seat_number;
                    cnt_next      = '0;
                    found_next    = 1'b0;
                    free_ok_next  = 1'b0;
                    l1_ok_next    = 1'b0;
                    l2_ok_next    = 1'b0;
                    status_next   = ST_OK;
                    seat_out_next = '0;
                    if (cmd.func == FN_REGISTER || cmd.func == FN_RELEASE)
                        state_next = S_SCAN;
                    else
                        state_next = S_UPDATE;
                end
            end
            S_SCAN:
            begin
                // Issue the read of seat cnt, compare the seat read last cycle.
                cmp_idx_next = cnt_reg[IW-1:0];
                if (cnt_reg != '0)
                begin
                    if (cmp_match && !found_reg)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = cmp_idx_reg;
                    end
                    if (!cmp_used && !free_ok_reg)
                    begin
                        free_ok_next  = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                    if (cmp_used && !l1_ok_reg)
                    begin
                        l1_ok_next  = 1'b1;
                        l1_idx_next = cmp_idx_reg;
                    end
                    else if (cmp_used && !l2_ok_reg)
                    begin
                        l2_ok_next  = 1'b1;
                        l2_idx_next = cmp_idx_reg;
                    end
                end
                if (cnt_reg == AW'(NUM_SEATS))
                    state_next = S_UPDATE;
                else
                    cnt_next = cnt_reg + AW'(1);
            end
            S_UPDATE:
            begin
                unique case (func_reg)
                    FN_REGISTER:
                    begin
                        if (found_reg)
                            seat_out_next = AW'(found_idx_reg) + AW'(1);
                        else if (free_ok_reg)
                        begin
                            mem_req.wr_en           = 1'b1;
                            used_next[free_idx_reg] = 1'b1;
                            count_next              = count_reg + AW'(1);
                            seat_out_next           = AW'(free_idx_reg) + AW'(1);
                            if (active_reg == '0)
                                active_next = AW'(free_idx_reg) + AW'(1);
                        end
                        else
                            status_next = ST_FULL;
                    end
                    FN_RELEASE:
                    begin
                        if (found_reg)
                        begin
                            used_next[found_idx_reg] = 1'b0;
                            count_next               = count_reg - AW'(1);
                            // Fall back to the lowest seat left in use.
                            if (active_reg == AW'(found_idx_reg) + AW'(1))
                            begin
                                if (l1_idx_reg != found_idx_reg)
                                    active_next = AW'(l1_idx_reg) + AW'(1);
                                else if (l2_ok_reg)
                                    active_next = AW'(l2_idx_reg) + AW'(1);
                                else
                                    active_next = '0;
                            end
                        end
                    end
                    FN_SWITCH:
                    begin
                        if (seat_ok)
                            active_next = AW'(sn_reg);
                        else
                            status_next = ST_BAD_SEAT;
                    end
                    FN_READ:
                    begin
                        if (!seat_ok)
                            status_next = ST_BAD_SEAT;
                    end
                    default: status_next = status_reg;
                endcase
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                mem_req.own_idx = IDX_MAX_W'(act_idx);
                state_next      = S_RESULT;
            end
            S_RESULT:
            begin
                // Hold the active owner read while the result waits.
                mem_req.own_idx = IDX_MAX_W'(act_idx);
                if (res_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        res_data              = '0;
        res_data.status       = status_reg;
        res_data.seat_out     = SEAT_W'(seat_out_reg);
        res_data.address_out  = (func_reg == FN_READ && seat_ok) ? addr_rd : '0;
        res_data.active_seat  = SEAT_W'(active_reg);
        res_data.active_valid = act_ok;
        res_data.active_owner = act_ok ? owner_rd : '0;
        res_data.used_count   = SEAT_W'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            active_reg    <= '0;
            count_reg     <= '0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            free_ok_reg   <= 1'b0;
            l1_ok_reg     <= 1'b0;
            l2_ok_reg     <= 1'b0;
            status_reg    <= ST_OK;
            seat_out_reg  <= '0;
            func_reg      <= FN_REGISTER;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            active_reg    <= active_next;
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            free_ok_reg   <= free_ok_next;
            l1_ok_reg     <= l1_ok_next;
            l2_ok_reg     <= l2_ok_next;
            status_reg    <= status_next;
            seat_out_reg  <= seat_out_next;
            func_reg      <= func_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg        <= id_next;
        addr_reg      <= addr_next;
        sn_reg        <= sn_next;
        cmp_idx_reg   <= cmp_idx_next;
        found_idx_reg <= found_idx_next;
        free_idx_reg  <= free_idx_next;
        l1_idx_reg    <= l1_idx_next;
        l2_idx_reg    <= l2_idx_next;
    end

endmodule

// ===== sv/display_seat_owner_table.sv =====
// Register and release scan one seat per cycle through the owner compare on the memory
// read port. A new request is taken only after the sequencer hands on its last result.
// Switch and read skip the scan.
// A held result does not stop the sequencer until its next result is ready.
// Reset (rst_n, asynchronous) frees all seats and clears the active seat at once.
`timescale 1ns / 1ps

module display_seat_owner_table
    import dsot_pkg::*;
#(
    parameter int NUM_SEATS = NUM_SEATS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    dsot_cmd_if.sink  cmd,
    dsot_res_if.source rsp
);

    mem_req_t           mem_req;
    logic [OWNER_W-1:0] owner_rd;
    logic [ADDR_W-1:0]  addr_rd;
    logic               seq_vld;
    logic               seq_ready;
    result_t            seq_data;

    logic               out_vld_reg;
    result_t            out_data_reg;

    dsot_mem #(
        .NUM_SEATS (NUM_SEATS)
    ) u_mem (
        .clk      (clk),
        .req      (mem_req),
        .owner_rd (owner_rd),
        .addr_rd  (addr_rd)
    );

    dsot_seq #(
        .NUM_SEATS (NUM_SEATS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .mem_req   (mem_req),
        .owner_rd  (owner_rd),
        .addr_rd   (addr_rd),
        .res_vld   (seq_vld),
        .res_ready (seq_ready),
        .res_data  (seq_data)
    );

    // Load the output register when it is empty or being drained.
    assign seq_ready = !out_vld_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (seq_ready)
            out_vld_reg <= seq_vld;
    end

    always_ff @(posedge clk)
    begin
        if (seq_ready && seq_vld)
            out_data_reg <= seq_data;
    end

    assign rsp.valid        = out_vld_reg;
    assign rsp.status       = out_data_reg.status;
    assign rsp.seat_out     = out_data_reg.seat_out;
    assign rsp.address_out  = out_data_reg.address_out;
    assign rsp.active_seat  = out_data_reg.active_seat;
    assign rsp.active_valid = out_data_reg.active_valid;
    assign rsp.active_owner = out_data_reg.active_owner;
    assign rsp.used_count   = out_data_reg.used_count;

`ifndef SYNTH
    a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !seq_vld)
        else $error("sequencer result right after a request was taken");

    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> !seq_vld)
        else $error("sequencer idle while a result is pending");

    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        seq_vld && seq_ready |=> rsp.valid)
        else $error("finished result not loaded into output register");
`endif

endmodule
